FILE: src/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants of the switch frame pulse encoder
// Holds the command codes, the register indexes, the timing register bundle
// and the classified command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rfe_pkg;

  // Number of level bits that a dim frame carries.
  localparam int LEVEL_BITS = 4;
  localparam logic [3:0] LEVEL_MAX = 4'd15;

  // Reset values of the timing registers, in ticks.
  localparam logic [15:0] SHORT_RST     = 16'd275;
  localparam logic [15:0] LONG_RST      = 16'd1375;
  localparam logic [15:0] START_GAP_RST = 16'd2750;
  localparam logic [15:0] END_GAP_RST   = 16'd11000;

  typedef enum logic [1:0] {
    ACT_ON  = 2'd0,
    ACT_OFF = 2'd1,
    ACT_DIM = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_SHORT     = 2'd0,
    CFG_LONG      = 2'd1,
    CFG_START_GAP = 2'd2,
    CFG_END_GAP   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] start_gap_ticks;
    logic [15:0] end_gap_ticks;
  } timing_t;

  // Classified command; address and unit travel beside it.
  typedef struct packed {
    logic                  kind;
    logic                  start_ok;
    action_e               action;
    logic [LEVEL_BITS-1:0] level;
    logic [7:0]            reps;
  } cmd_t;

endpackage

FILE: src/rfe_if.sv
// ----------------------------------------------------------------------------
// rfe_if: channel interfaces of the switch frame pulse encoder
// The tick channel carries one timing tick with an optional command, the
// result channel carries the pin level and status of that tick.
// ----------------------------------------------------------------------------
interface rfe_tick_if #(
  parameter int ADDRESS_BITS = 26,
  parameter int UNIT_BITS    = 4
) ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [1:0]              action;
  logic [ADDRESS_BITS-1:0] device_address;
  logic [UNIT_BITS-1:0]    unit_number;
  logic [6:0]              dim_percent;
  logic [7:0]              repeat_count;

  modport source (
    output valid, kind, action, device_address, unit_number, dim_percent, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, kind, action, device_address, unit_number, dim_percent, repeat_count,
    output ready
  );
endinterface

interface rfe_result_if ();
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic rejected;

  modport source (
    output valid, pin_level, busy_res, rejected,
    input  ready
  );
  modport sink (
    input  valid, pin_level, busy_res, rejected,
    output ready
  );
endinterface

FILE: src/rfe_front.sv
// ----------------------------------------------------------------------------
// rfe_front: input stage of the switch frame pulse encoder
// Registers each tick, checks the command code and turns the dim percent
// into a four-bit level before the item enters the queue.
// ----------------------------------------------------------------------------
module rfe_front #(
  parameter int ADDRESS_BITS = 26,
  parameter int UNIT_BITS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rfe_tick_if.sink                tick_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output rfe_pkg::cmd_t           cmd_o,
  output logic [ADDRESS_BITS-1:0] addr_o,
  output logic [UNIT_BITS-1:0]    unit_o
);
  import rfe_pkg::*;

  logic        valid_q;
  cmd_t        cmd_d, cmd_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [UNIT_BITS-1:0]    unit_q;
  logic [10:0] scaled;
  logic [16:0] recip;
  logic [4:0]  quot;
  logic        take;

  assign tick_i.ready = !valid_q || !q_full_i;
  assign take         = tick_i.valid && tick_i.ready;
  assign q_push_o     = valid_q;

  // percent * 15 / 100: the product is a multiple of 15 below 2048, where
  // 41 / 4096 gives the exact floor of the division by 100.
  always_comb begin
    scaled = {tick_i.dim_percent, 4'b0000} - {4'b0000, tick_i.dim_percent};
    recip  = {6'd0, scaled} * 17'd41;
    quot   = recip[16:12];
    cmd_d.kind     = tick_i.kind;
    cmd_d.start_ok = (tick_i.action == ACT_ON) || (tick_i.action == ACT_OFF) ||
                     (tick_i.action == ACT_DIM);
    cmd_d.action   = action_e'(tick_i.action);
    cmd_d.level    = (quot > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : quot[3:0];
    cmd_d.reps     = tick_i.repeat_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (!q_full_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q  <= cmd_d;
      addr_q <= tick_i.device_address;
      unit_q <= tick_i.unit_number;
    end
  end

  assign cmd_o  = cmd_q;
  assign addr_o = addr_q;
  assign unit_o = unit_q;

endmodule

FILE: src/rfe_fifo.sv
// ----------------------------------------------------------------------------
// rfe_fifo: two-entry queue between front and back end
// Lets the input side and the frame engine stall independently.
// ----------------------------------------------------------------------------
module rfe_fifo #(
  parameter int WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/rfe_back.sv
// ----------------------------------------------------------------------------
// rfe_back: frame engine of the switch frame pulse encoder
// Takes one tick a cycle from the queue unless result_o stalls, starts or
// rejects commands, walks the frame segment by segment and registers its result.
// ----------------------------------------------------------------------------
module rfe_back #(
  parameter int ADDRESS_BITS = 26,
  parameter int UNIT_BITS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rfe_pkg::timing_t        timing_i,
  input  logic                    q_valid_i,
  input  rfe_pkg::cmd_t           cmd_i,
  input  logic [ADDRESS_BITS-1:0] addr_i,
  input  logic [UNIT_BITS-1:0]    unit_i,
  output logic                    q_pop_o,
  rfe_result_if.source            result_o
);
  import rfe_pkg::*;

  // Symbols: address, group bit, command, unit and (dim only) level.
  localparam int NSYM          = ADDRESS_BITS + 2 + UNIT_BITS + LEVEL_BITS;
  localparam int SEG_W         = $clog2(2 + 4 * NSYM + 4);
  localparam int K_W           = SEG_W - 2;
  localparam int SYM_END_PLAIN = 2 + 4 * (NSYM - LEVEL_BITS);
  localparam int SYM_END_DIM   = 2 + 4 * NSYM;
  localparam int CMD_SYM       = ADDRESS_BITS + 1;

  logic [15:0]             pc_q, pc_e, pc_d;
  logic [SEG_W-1:0]        seg_q, seg_e, seg_d;
  logic [7:0]              rep_q, rep_e, rep_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_e;
  logic [UNIT_BITS-1:0]    unit_q, unit_e;
  action_e                 act_q, act_e;
  logic [LEVEL_BITS-1:0]   lvl_q, lvl_e;

  logic ov_q, pin_q, busy_q, rej_q;
  logic advance, pop, start, rej, run, dim;

  logic [SEG_W-1:0] sym_end, rel, rest;
  logic [K_W-1:0]   k;
  logic [1:0]       s;
  logic [NSYM-1:0]  data_vec, rev, rev_sh;
  logic             sym_bit, dim_sym, long_low;
  logic             hi, last;
  logic [15:0]      len;
  logic [16:0]      cnt;
  logic             done;

  assign advance = !ov_q || result_o.ready;
  assign pop     = q_valid_i && advance;
  assign q_pop_o = pop;

  // Effective state for this tick: a start reloads everything first.
  always_comb begin
    start  = cmd_i.kind && (rep_q == 8'd0) && cmd_i.start_ok;
    rej    = cmd_i.kind && (rep_q != 8'd0);
    pc_e   = start ? 16'd0 : pc_q;
    seg_e  = start ? '0 : seg_q;
    rep_e  = start ? cmd_i.reps : rep_q;
    addr_e = start ? addr_i : addr_q;
    unit_e = start ? unit_i : unit_q;
    act_e  = start ? cmd_i.action : act_q;
    lvl_e  = start ? cmd_i.level : lvl_q;
    run    = rep_e != 8'd0;
  end

  // Segment decode.
  always_comb begin
    dim      = act_e == ACT_DIM;
    sym_end  = dim ? SEG_W'(SYM_END_DIM) : SEG_W'(SYM_END_PLAIN);
    rel      = seg_e - SEG_W'(2);
    k        = rel[SEG_W-1:2];
    s        = rel[1:0];
    rest     = seg_e - sym_end;
    data_vec = {addr_e, 1'b0, act_e == ACT_ON, unit_e, lvl_e};
    for (int i = 0; i < NSYM; i++) begin
      rev[i] = data_vec[NSYM-1-i];
    end
    rev_sh   = rev >> k;
    sym_bit  = rev_sh[0];
    dim_sym  = dim && (k == K_W'(CMD_SYM));
    // A one has its long low first, a zero has it second.
    long_low = !dim_sym && (sym_bit == !s[1]);
    last     = 1'b0;
    if (seg_e < SEG_W'(2)) begin
      hi  = seg_e == '0;
      len = hi ? timing_i.short_ticks : timing_i.start_gap_ticks;
    end else if (seg_e < sym_end) begin
      hi  = !s[0];
      len = (s[0] && long_low) ? timing_i.long_ticks : timing_i.short_ticks;
    end else begin
      hi   = dim ? (rest <= SEG_W'(2)) : (rest == '0);
      len  = hi ? timing_i.short_ticks : timing_i.end_gap_ticks;
      last = !hi;
    end
    cnt  = {1'b0, pc_e} + 17'd1;
    done = cnt >= {1'b0, len};
  end

  always_comb begin
    pc_d  = pc_e;
    seg_d = seg_e;
    rep_d = rep_e;
    if (run) begin
      if (done) begin
        pc_d = 16'd0;
        if (last) begin
          seg_d = '0;
          rep_d = rep_e - 8'd1;
        end else begin
          seg_d = seg_e + SEG_W'(1);
        end
      end else begin
        pc_d = cnt[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= 16'd0;
      seg_q  <= '0;
      rep_q  <= 8'd0;
      addr_q <= '0;
      unit_q <= '0;
      act_q  <= ACT_ON;
      lvl_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop) begin
        pc_q   <= pc_d;
        seg_q  <= seg_d;
        rep_q  <= rep_d;
        addr_q <= addr_e;
        unit_q <= unit_e;
        act_q  <= act_e;
        lvl_q  <= lvl_e;
      end
      if (advance) begin
        ov_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pin_q  <= run && hi;
      busy_q <= run;
      rej_q  <= rej;
    end
  end

  assign result_o.valid     = ov_q;
  assign result_o.pin_level = pin_q;
  assign result_o.busy_res  = busy_q;
  assign result_o.rejected  = rej_q;

endmodule

FILE: src/rf_switch_frame_pulse_encoder.sv
// ----------------------------------------------------------------------------
// rf_switch_frame_pulse_encoder: self-learning 433 MHz switch frame encoder
// Turns on, off and dim commands into the pulse train of a radio data pin.
// ----------------------------------------------------------------------------
// Every item on tick_i is one timing tick; every tick produces exactly one
// item on result_o with the pin level, a busy flag and a rejected flag for
// that tick. A tick whose kind is set carries a command: when the encoder
// is idle a valid command is latched and its first frame starts on that
// very tick, and when it is busy the command is dropped and flagged as
// rejected. The timing registers (short, long, start gap and end gap, in
// ticks) are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while the block is idle, the block does not enforce
// it. A tick passes an input register, a two-entry queue and the frame engine,
// whose output register presents the result. One tick is taken every cycle
// when nothing stalls: the frame engine updates its counters once per tick.
// When the receiver holds result_o.ready low, the engine stops and the input
// register and the two queue entries take at most three more items, after
// which tick_i.ready drops; no item is lost. Reset clears the frame state
// but not the result data: nothing is busy, no result is valid and the
// timing registers return to 275, 1375, 2750 and 11000 ticks.
// ----------------------------------------------------------------------------
module rf_switch_frame_pulse_encoder #(
  parameter int ADDRESS_BITS = 26,
  parameter int UNIT_BITS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfe_tick_if.sink    tick_i,
  rfe_result_if.source result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import rfe_pkg::*;

  localparam int Q_WIDTH = ADDRESS_BITS + UNIT_BITS + $bits(cmd_t);

  // Timing registers. Every index of the port names a register.
  timing_t timing_q, timing_d;

  always_comb begin
    timing_d = timing_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SHORT:     timing_d.short_ticks     = cfg_data_i;
        CFG_LONG:      timing_d.long_ticks      = cfg_data_i;
        CFG_START_GAP: timing_d.start_gap_ticks = cfg_data_i;
        CFG_END_GAP:   timing_d.end_gap_ticks   = cfg_data_i;
        default:       timing_d = timing_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.short_ticks     <= SHORT_RST;
      timing_q.long_ticks      <= LONG_RST;
      timing_q.start_gap_ticks <= START_GAP_RST;
      timing_q.end_gap_ticks   <= END_GAP_RST;
    end else begin
      timing_q <= timing_d;
    end
  end

  // Front end: registers and classifies each tick.
  logic                    q_full, q_push, q_valid, q_pop;
  cmd_t                    f_cmd, b_cmd;
  logic [ADDRESS_BITS-1:0] f_addr, b_addr;
  logic [UNIT_BITS-1:0]    f_unit, b_unit;

  rfe_front #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .UNIT_BITS   (UNIT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .cmd_o   (f_cmd),
    .addr_o  (f_addr),
    .unit_o  (f_unit)
  );

  // Queue between the two halves.
  rfe_fifo #(
    .WIDTH(Q_WIDTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({f_addr, f_unit, f_cmd}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o ({b_addr, b_unit, b_cmd})
  );

  // Back end: frame engine and result register.
  rfe_back #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .UNIT_BITS   (UNIT_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .timing_i (timing_q),
    .q_valid_i(q_valid),
    .cmd_i    (b_cmd),
    .addr_i   (b_addr),
    .unit_i   (b_unit),
    .q_pop_o  (q_pop),
    .result_o (result_o)
  );

endmodule
